/* rtl/wdfot_pkg.sv */
// ============================================================================
// wdfot_pkg
// Shared types, constants and tables for the WDF output tone filter.
// ============================================================================
`default_nettype none

package wdfot_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 30;

    localparam int COEF_W     = 32;
    localparam int WAVE_W     = 32;
    localparam int WIDE_W     = 128;
    localparam int OPND_W     = 64;
    localparam int NUM_COEF   = 7;
    localparam int NUM_TMP    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OHMS_W     = 20;
    localparam int PROD_W     = 65;
    localparam int DACC_W     = 67;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZBIG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZSMALL = 3'd4;

    localparam logic [OPND_W-1:0] MEGA        = 64'd1000000;
    localparam logic [OPND_W-1:0] R_HIGH_OHMS = 64'd13200;
    localparam logic [OPND_W-1:0] R_LOW_OHMS  = 64'd33000;
    localparam logic [OPND_W-1:0] TWO_OHM_Q16 = 64'd131072;

    localparam logic              RST_RANGE  = 1'b1;
    localparam logic [OHMS_W-1:0] RST_TONE   = 20'd50000;
    localparam logic [OHMS_W-1:0] RST_VOLUME = 20'd50000;
    localparam logic [31:0]       RST_ZBIG   = 32'd68267;
    localparam logic [31:0]       RST_ZSMALL = 32'd14524809;

    localparam logic [1:0] WAVE_X     = 2'd0;
    localparam logic [1:0] WAVE_BIG   = 2'd1;
    localparam logic [1:0] WAVE_SMALL = 2'd2;

    typedef struct packed {
        logic [2:0] coef;
        logic [1:0] wave;
        logic       neg;
    } mac_t;

    // nine MACs: output, big-cap wave, small-cap wave, three terms each
    function automatic mac_t mac_entry(input logic [3:0] m);
        mac_t e;
        e = '0;
        unique case (m)
            4'd0: e = '{coef: 3'd0, wave: WAVE_X,     neg: 1'b0};
            4'd1: e = '{coef: 3'd0, wave: WAVE_BIG,   neg: 1'b1};
            4'd2: e = '{coef: 3'd1, wave: WAVE_SMALL, neg: 1'b0};
            4'd3: e = '{coef: 3'd2, wave: WAVE_X,     neg: 1'b0};
            4'd4: e = '{coef: 3'd3, wave: WAVE_BIG,   neg: 1'b0};
            4'd5: e = '{coef: 3'd4, wave: WAVE_SMALL, neg: 1'b0};
            4'd6: e = '{coef: 3'd5, wave: WAVE_X,     neg: 1'b0};
            4'd7: e = '{coef: 3'd5, wave: WAVE_BIG,   neg: 1'b1};
            4'd8: e = '{coef: 3'd6, wave: WAVE_SMALL, neg: 1'b0};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

/* rtl/wdf_output_tone_filter_core.sv */
// ============================================================================
// wdf_output_tone_filter_core
// Wave digital filter output tone stage with two capacitor wave states.
// ============================================================================
// Usage:
//   s_axis carries one signed sample word in, m_axis one filtered sample out.
//   cfg writes a register (0 range, 1 tone, 2 volume, 3 big-cap impedance,
//   4 small-cap impedance); write only while idle. Any write in range marks
//   the coefficients stale.
//   With fresh coefficients each sample takes 9 MACs on one 32x33
//   multiplier, one pipelined accumulate, then the output load.
//   The first sample after a config write first recomputes the seven
//   coefficients on a shared 128-bit adder: 14 shift-add multiplies (one
//   multiplier bit per cycle) and 7 restoring divides.
//   s_axis_tready is high only while the sequencer is idle.
//   A finished result sits in the m_axis output register; if the receiver
//   stalls, the next result waits until that word is taken.
//   Reset: waves cleared, registers to defaults, coefficients stale.
// ============================================================================
`default_nettype none

module wdf_output_tone_filter_core
    import wdfot_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    localparam int TDATA_W       = ((SAMPLE_BITS + 7) / 8) * 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [TDATA_W-1:0]    s_axis_tdata,   // sample_in
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [TDATA_W-1:0]         m_axis_tdata,   // sample_out
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CLOAD  = 4'd1;
    localparam logic [3:0] ST_CMUL   = 4'd2;
    localparam logic [3:0] ST_CDIFF  = 4'd3;
    localparam logic [3:0] ST_CNEG   = 4'd4;
    localparam logic [3:0] ST_CDVD   = 4'd5;
    localparam logic [3:0] ST_CDIV   = 4'd6;
    localparam logic [3:0] ST_CSTORE = 4'd7;
    localparam logic [3:0] ST_DOT    = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    localparam logic [3:0] STEP_TA   = 4'd0;
    localparam logic [3:0] STEP_TB   = 4'd1;
    localparam logic [3:0] STEP_TC   = 4'd2;
    localparam logic [3:0] STEP_TE   = 4'd3;
    localparam logic [3:0] STEP_TF   = 4'd4;
    localparam logic [3:0] STEP_D0   = 4'd5;
    localparam logic [3:0] STEP_D1   = 4'd6;
    localparam logic [3:0] STEP_K0   = 4'd7;
    localparam logic [3:0] STEP_K1   = 4'd8;
    localparam logic [3:0] STEP_K2   = 4'd9;
    localparam logic [3:0] STEP_K3   = 4'd10;
    localparam logic [3:0] STEP_K4   = 4'd11;
    localparam logic [3:0] STEP_K5   = 4'd12;
    localparam logic [3:0] STEP_K6   = 4'd13;

    localparam logic [3:0] DOT_Y_END = 4'd3;
    localparam logic [3:0] DOT_B_END = 4'd6;
    localparam logic [3:0] DOT_S_END = 4'd9;

    localparam logic [6:0] DIV_LAST  = 7'd127;

    localparam logic signed [DACC_W-1:0] HALF_Y = DACC_W'(1) <<< COEF_FRAC_BITS;
    localparam logic signed [DACC_W-1:0] HALF_W = DACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [DACC_W-1:0] Y_MAX  = (DACC_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [DACC_W-1:0] Y_MIN  = -(DACC_W'(1) <<< (SAMPLE_BITS - 1));
    localparam logic signed [DACC_W-1:0] W_MAX  = (DACC_W'(1) <<< (WAVE_W - 1)) - 1;
    localparam logic signed [DACC_W-1:0] W_MIN  = -(DACC_W'(1) <<< (WAVE_W - 1));

    logic [3:0] state_reg;
    logic [3:0] cstep_reg;
    logic [3:0] dstep_reg;
    logic [6:0] cnt_reg;

    logic              range_reg;
    logic [OHMS_W-1:0] tone_reg;
    logic [OHMS_W-1:0] volume_reg;
    logic [31:0]       zbig_reg;
    logic [31:0]       zsmall_reg;
    logic              coef_valid_reg;

    logic [OPND_W-1:0] tmp_reg [NUM_TMP];
    logic [WIDE_W-1:0] acc_reg;
    logic [WIDE_W-1:0] mcand_reg;
    logic [OPND_W-1:0] mplier_reg;
    logic [WIDE_W-1:0] d_reg;
    logic [WIDE_W-1:0] n_reg;
    logic              neg_reg;

    logic signed [COEF_W-1:0]      coef_reg [NUM_COEF];
    logic signed [WAVE_W-1:0]      x_reg;
    logic signed [WAVE_W-1:0]      wb_reg;
    logic signed [WAVE_W-1:0]      ws_reg;
    logic signed [WAVE_W-1:0]      nb_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [DACC_W-1:0]      dacc_reg;

    logic               out_valid_reg;
    logic [TDATA_W-1:0] out_data_reg;

    // configuration-derived operands, Q16.16 ohms
    logic [OPND_W-1:0] r_ohm, x4, x5, z10, z11, rz10, x4z11, s_sum;

    always_comb
    begin
        r_ohm = (range_reg ? R_HIGH_OHMS : R_LOW_OHMS) << 16;
        x4    = OPND_W'(tone_reg) << 16;
        x5    = OPND_W'(volume_reg) << 16;
        z10   = OPND_W'(zbig_reg);
        z11   = OPND_W'(zsmall_reg);
        rz10  = r_ohm + z10;
        x4z11 = x4 + z11;
        s_sum = x4z11 + x5;
    end

    // multiply operand table
    logic [OPND_W-1:0] op_a, op_b;
    logic [WIDE_W-1:0] op_init;

    always_comb
    begin
        op_a    = '0;
        op_b    = '0;
        op_init = '0;
        unique case (cstep_reg)
            STEP_TA: begin op_a = rz10;  op_b = MEGA; end
            STEP_TB: begin op_a = x4z11; op_b = MEGA; end
            STEP_TC: begin op_a = z10;   op_b = MEGA; end
            STEP_TE: begin op_a = z11;   op_b = MEGA; end
            STEP_TF: begin op_a = x5;    op_b = MEGA; end
            STEP_D0:
            begin
                op_a    = s_sum;
                op_b    = tmp_reg[STEP_TA[2:0]];
                op_init = WIDE_W'(s_sum) << 16;
            end
            STEP_D1:
            begin
                op_a    = x5;
                op_b    = tmp_reg[STEP_TB[2:0]];
                op_init = acc_reg;
            end
            STEP_K0: begin op_a = x5; op_b = tmp_reg[STEP_TB[2:0]] << 1; end
            STEP_K1: begin op_a = x5; op_b = (tmp_reg[STEP_TA[2:0]] << 1) + TWO_OHM_Q16; end
            STEP_K2: begin op_a = s_sum; op_b = tmp_reg[STEP_TC[2:0]] << 1; end
            STEP_K3: begin op_a = s_sum; op_b = tmp_reg[STEP_TC[2:0]] << 1; end
            STEP_K4: begin op_a = x5; op_b = tmp_reg[STEP_TC[2:0]] << 1; end
            STEP_K5: begin op_a = x5; op_b = tmp_reg[STEP_TE[2:0]] << 1; end
            STEP_K6:
            begin
                op_a = z11;
                op_b = ((tmp_reg[STEP_TA[2:0]] + tmp_reg[STEP_TF[2:0]]) << 1) + TWO_OHM_Q16;
            end
            default: ;
        endcase
    end

    // shared wide adder
    logic [WIDE_W-1:0] add_a, add_b, rem_sh;
    logic              add_sub;
    logic [WIDE_W:0]   add_sum;
    logic              add_carry;

    always_comb
    begin
        rem_sh  = {acc_reg[WIDE_W-2:0], mcand_reg[WIDE_W-1]};
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            ST_CMUL:
            begin
                add_a = acc_reg;
                add_b = mplier_reg[0] ? mcand_reg : '0;
            end
            ST_CDIFF: begin add_a = d_reg; add_b = n_reg; add_sub = 1'b1; end
            ST_CNEG:  begin add_a = n_reg; add_b = d_reg; add_sub = 1'b1; end
            ST_CDVD:  begin add_a = n_reg << COEF_FRAC_BITS; add_b = d_reg >> 1; end
            ST_CDIV:  begin add_a = rem_sh; add_b = d_reg; add_sub = 1'b1; end
            default: ;
        endcase
        add_sum   = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                    + (WIDE_W + 1)'(add_sub);
        add_carry = add_sum[WIDE_W];
    end

    // coefficient saturation from the quotient
    logic [2:0]               kidx;
    logic                     q_big;
    logic signed [COEF_W-1:0] coef_next;

    always_comb
    begin
        kidx  = 3'(cstep_reg - STEP_K0);
        q_big = |mcand_reg[WIDE_W-1:COEF_W-1];
        priority if (d_reg == '0)
            coef_next = '0;
        else if (neg_reg)
            coef_next = q_big ? {1'b1, {(COEF_W-1){1'b0}}} : -$signed(mcand_reg[COEF_W-1:0]);
        else
            coef_next = q_big ? {1'b0, {(COEF_W-1){1'b1}}} : $signed(mcand_reg[COEF_W-1:0]);
    end

    // dot-product datapath
    mac_t                     mac;
    logic signed [COEF_W-1:0] c_op;
    logic signed [WAVE_W-1:0] w_sel;
    logic signed [WAVE_W:0]   w_op;
    logic signed [DACC_W-1:0] dsum, sh_y, sh_w;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic signed [WAVE_W-1:0] w_next;

    always_comb
    begin
        mac  = mac_entry(dstep_reg);
        c_op = coef_reg[mac.coef];
        unique case (mac.wave)
            WAVE_X:     w_sel = x_reg;
            WAVE_BIG:   w_sel = wb_reg;
            WAVE_SMALL: w_sel = ws_reg;
            default:    w_sel = '0;
        endcase
        w_op = mac.neg ? -(WAVE_W + 1)'(w_sel) : (WAVE_W + 1)'(w_sel);
        dsum = dacc_reg + DACC_W'(prod_reg);
        sh_y = dsum >>> (COEF_FRAC_BITS + 1);
        sh_w = dsum >>> COEF_FRAC_BITS;
        priority if (sh_y > Y_MAX)
            y_next = Y_MAX[SAMPLE_BITS-1:0];
        else if (sh_y < Y_MIN)
            y_next = Y_MIN[SAMPLE_BITS-1:0];
        else
            y_next = sh_y[SAMPLE_BITS-1:0];
        priority if (sh_w > W_MAX)
            w_next = W_MAX[WAVE_W-1:0];
        else if (sh_w < W_MIN)
            w_next = W_MIN[WAVE_W-1:0];
        else
            w_next = sh_w[WAVE_W-1:0];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                x_reg <= WAVE_W'($signed(s_axis_tdata[SAMPLE_BITS-1:0]));
            end
            ST_CLOAD:
            begin
                mcand_reg  <= WIDE_W'(op_a);
                mplier_reg <= op_b;
                acc_reg    <= op_init;
            end
            ST_CMUL:
            begin
                if (mplier_reg == '0)
                begin
                    if (cstep_reg <= STEP_TF)
                        tmp_reg[cstep_reg[2:0]] <= acc_reg[OPND_W-1:0];
                    else if (cstep_reg == STEP_D1)
                        d_reg <= acc_reg;
                    else if (cstep_reg >= STEP_K0)
                    begin
                        n_reg   <= acc_reg;
                        neg_reg <= (cstep_reg == STEP_K4);
                    end
                end
                else
                begin
                    acc_reg    <= add_sum[WIDE_W-1:0];
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end
            end
            ST_CDIFF:
            begin
                if (add_carry)
                begin
                    n_reg   <= add_sum[WIDE_W-1:0];
                    neg_reg <= 1'b0;
                end
            end
            ST_CNEG:
            begin
                n_reg   <= add_sum[WIDE_W-1:0];
                neg_reg <= 1'b1;
            end
            ST_CDVD:
            begin
                mcand_reg <= add_sum[WIDE_W-1:0];
                acc_reg   <= '0;
            end
            ST_CDIV:
            begin
                acc_reg   <= add_carry ? add_sum[WIDE_W-1:0] : rem_sh;
                mcand_reg <= {mcand_reg[WIDE_W-2:0], add_carry};
            end
            ST_CSTORE:
            begin
                coef_reg[kidx] <= coef_next;
            end
            ST_DOT:
            begin
                if (dstep_reg < DOT_S_END)
                    prod_reg <= c_op * w_op;
                priority if (dstep_reg == '0)
                    dacc_reg <= HALF_Y;
                else if (dstep_reg == DOT_Y_END)
                begin
                    y_reg    <= y_next;
                    dacc_reg <= HALF_W;
                end
                else if (dstep_reg == DOT_B_END)
                begin
                    nb_reg   <= w_next;
                    dacc_reg <= HALF_W;
                end
                else
                    dacc_reg <= dsum;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                    out_data_reg <= TDATA_W'($unsigned(y_reg));
            end
            default: ;
        endcase
    end

    // control, configuration and wave state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cstep_reg      <= '0;
            dstep_reg      <= '0;
            cnt_reg        <= '0;
            range_reg      <= RST_RANGE;
            tone_reg       <= RST_TONE;
            volume_reg     <= RST_VOLUME;
            zbig_reg       <= RST_ZBIG;
            zsmall_reg     <= RST_ZSMALL;
            coef_valid_reg <= 1'b0;
            wb_reg         <= '0;
            ws_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_RANGE:  range_reg  <= cfg_data[0];
                    REG_TONE:   tone_reg   <= cfg_data[OHMS_W-1:0];
                    REG_VOLUME: volume_reg <= cfg_data[OHMS_W-1:0];
                    REG_ZBIG:   zbig_reg   <= cfg_data;
                    REG_ZSMALL: zsmall_reg <= cfg_data;
                    default: ;
                endcase
                if (cfg_index <= REG_ZSMALL)
                    coef_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        dstep_reg <= '0;
                        cstep_reg <= STEP_TA;
                        state_reg <= coef_valid_reg ? ST_DOT : ST_CLOAD;
                    end
                end
                ST_CLOAD:
                begin
                    state_reg <= ST_CMUL;
                end
                ST_CMUL:
                begin
                    if (mplier_reg == '0)
                    begin
                        priority if (cstep_reg < STEP_K0)
                        begin
                            cstep_reg <= cstep_reg + 4'd1;
                            state_reg <= ST_CLOAD;
                        end
                        else if (cstep_reg == STEP_K3 || cstep_reg == STEP_K6)
                            state_reg <= ST_CDIFF;
                        else
                            state_reg <= ST_CDVD;
                    end
                end
                ST_CDIFF:
                begin
                    state_reg <= add_carry ? ST_CDVD : ST_CNEG;
                end
                ST_CNEG:
                begin
                    state_reg <= ST_CDVD;
                end
                ST_CDVD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_CDIV;
                end
                ST_CDIV:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == DIV_LAST)
                        state_reg <= ST_CSTORE;
                end
                ST_CSTORE:
                begin
                    if (cstep_reg == STEP_K6)
                    begin
                        coef_valid_reg <= 1'b1;
                        dstep_reg      <= '0;
                        state_reg      <= ST_DOT;
                    end
                    else
                    begin
                        cstep_reg <= cstep_reg + 4'd1;
                        state_reg <= ST_CLOAD;
                    end
                end
                ST_DOT:
                begin
                    dstep_reg <= dstep_reg + 4'd1;
                    if (dstep_reg == DOT_S_END)
                    begin
                        wb_reg    <= nb_reg;
                        ws_reg    <= w_next;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
